FILE: sv/brightness_step_beep_persist_supervisor_assert.svh
// Assertion macros for the brightness supervisor checker.
// Depends on nothing; included by the checker file.
`ifndef BRIGHTNESS_STEP_BEEP_PERSIST_SUPERVISOR_ASSERT_SVH
`define BRIGHTNESS_STEP_BEEP_PERSIST_SUPERVISOR_ASSERT_SVH

// Property checked at every rising edge, ignored while reset is high.
`define BBPS_ASSERT_RUN(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define BBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bbps_pkg.sv
// Shared types and constants of the brightness step/beep/persist supervisor.
// Depends on nothing; used by the register file, core, top level, checker and bench by scoped names.
package bbps_pkg;

  // Request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_BRIGHT = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Brightness commands
  localparam logic [7:0] CMD_DOWN    = 8'd1;
  localparam logic [7:0] CMD_UP      = 8'd2;
  localparam logic [7:0] CMD_DEFAULT = 8'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAVE_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INDEX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_BYTES    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAVED_INIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_INIT   = 3'd7;

  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] SILENCE_LIMIT_RST = 16'd4000;
  localparam logic [15:0] BEEP_LENGTH_RST   = 16'd100;
  localparam logic [15:0] SAVE_DELAY_RST    = 16'd5000;
  localparam logic [7:0]  TOP_INDEX_RST     = 8'd15;
  localparam logic [7:0]  DEFAULT_INDEX_RST = 8'd7;
  localparam logic [15:0] PAGE_BYTES_RST    = 16'd1024;
  localparam logic [7:0]  SAVED_INIT_RST    = 8'd0;
  localparam logic [15:0] OFFSET_INIT_RST   = 16'd0;

  // Halfword step of the flash page
  localparam logic [15:0] HALFWORD_BYTES = 16'd2;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [15:0] silence_limit_ms;
    logic [15:0] beep_length_ms;
    logic [15:0] save_delay_ms;
    logic [7:0]  top_index;
    logic [7:0]  default_index;
    logic [15:0] page_bytes;
  } cfg_t;

  // Start-up values loaded into persistence state on a register write
  typedef struct packed {
    logic        load_saved;
    logic [7:0]  saved_value;
    logic        load_offset;
    logic [15:0] offset_value;
  } init_load_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] bright_cmd;
  } item_t;

  typedef struct packed {
    logic [7:0]  bright_level;
    logic        apply_level;
    logic        beep_active;
    logic        silence_alarm;
    logic        erase_page;
    logic        write_flash;
    logic [15:0] write_offset;
    logic [7:0]  write_value;
  } status_t;

endpackage

FILE: sv/bbps_stream_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Depends on nothing; payload types come from bbps_pkg at instantiation.
interface bbps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bbps_cfg_regs.sv
// Configuration register file of the brightness supervisor.
// Depends on bbps_pkg; feeds the core with settings and start-up loads.
module bbps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbps_pkg::CFG_DATA_W-1:0] cfg_data,
  output bbps_pkg::cfg_t                 cfg,
  output bbps_pkg::init_load_t           init_load
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.silence_limit_ms <= bbps_pkg::SILENCE_LIMIT_RST;
      cfg.beep_length_ms   <= bbps_pkg::BEEP_LENGTH_RST;
      cfg.save_delay_ms    <= bbps_pkg::SAVE_DELAY_RST;
      cfg.top_index        <= bbps_pkg::TOP_INDEX_RST;
      cfg.default_index    <= bbps_pkg::DEFAULT_INDEX_RST;
      cfg.page_bytes       <= bbps_pkg::PAGE_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbps_pkg::REG_SILENCE_LIMIT: cfg.silence_limit_ms <= cfg_data;
        bbps_pkg::REG_BEEP_LENGTH:   cfg.beep_length_ms   <= cfg_data;
        bbps_pkg::REG_SAVE_DELAY:    cfg.save_delay_ms    <= cfg_data;
        bbps_pkg::REG_TOP_INDEX:     cfg.top_index        <= cfg_data[7:0];
        bbps_pkg::REG_DEFAULT_INDEX: cfg.default_index    <= cfg_data[7:0];
        bbps_pkg::REG_PAGE_BYTES:    cfg.page_bytes       <= cfg_data;
        // start-up values live in the core state
        bbps_pkg::REG_SAVED_INIT, bbps_pkg::REG_OFFSET_INIT: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    init_load.load_saved   = cfg_we && (cfg_index == bbps_pkg::REG_SAVED_INIT);
    init_load.saved_value  = cfg_data[7:0];
    init_load.load_offset  = cfg_we && (cfg_index == bbps_pkg::REG_OFFSET_INIT);
    init_load.offset_value = cfg_data;
  end

endmodule

FILE: sv/bbps_core.sv
// Per-item step logic and supervisor state (level, counters, flash offset).
// Depends on bbps_pkg; driven by the top level's input register.
module bbps_core (
  input  logic                 clk,
  input  logic                 rst,
  input  bbps_pkg::cfg_t       cfg,
  input  bbps_pkg::init_load_t init_load,
  input  logic                 fire,
  input  bbps_pkg::item_t      item,
  output bbps_pkg::status_t    res
);

  logic [7:0]  level, level_next;
  logic [7:0]  saved_level, saved_level_next;
  logic [15:0] page_offset, page_offset_next;
  logic [15:0] quiet_count, quiet_count_next;
  logic        quiet_armed, quiet_armed_next;
  logic [15:0] beep_count, beep_count_next;
  logic        beep_on, beep_on_next;
  logic [15:0] change_count, change_count_next;
  logic        change_armed, change_armed_next;

  logic [15:0] quiet_inc, beep_inc, change_inc, woff;
  logic        alarm, save, erase, beep;

  always_comb begin
    quiet_inc  = (quiet_count == bbps_pkg::COUNT_MAX) ? quiet_count : quiet_count + 16'd1;
    beep_inc   = (beep_count == bbps_pkg::COUNT_MAX) ? beep_count : beep_count + 16'd1;
    change_inc = (change_count == bbps_pkg::COUNT_MAX) ? change_count : change_count + 16'd1;

    level_next        = level;
    saved_level_next  = saved_level;
    page_offset_next  = page_offset;
    quiet_count_next  = quiet_count;
    quiet_armed_next  = quiet_armed;
    beep_count_next   = beep_count;
    beep_on_next      = beep_on;
    change_count_next = change_count;
    change_armed_next = change_armed;

    alarm = 1'b0;
    save  = 1'b0;
    erase = 1'b0;
    beep  = 1'b0;
    woff  = 16'd0;

    unique case (item.req_type)
      bbps_pkg::REQ_TICK: begin
        quiet_count_next  = quiet_inc;
        beep_count_next   = beep_inc;
        change_count_next = change_inc;
        alarm = quiet_armed && (quiet_inc > cfg.silence_limit_ms);
        if (alarm) quiet_armed_next = 1'b0;
        if (beep_on && (beep_inc >= cfg.beep_length_ms)) beep_on_next = 1'b0;
        save  = change_armed && (level != saved_level) && (change_inc > cfg.save_delay_ms);
        erase = save && (page_offset >= cfg.page_bytes);
        if (save) begin
          woff              = erase ? 16'd0 : page_offset;
          page_offset_next  = woff + bbps_pkg::HALFWORD_BYTES;
          saved_level_next  = level;
          change_armed_next = 1'b0;
        end
      end
      bbps_pkg::REQ_FRAME: begin
        quiet_count_next = 16'd0;
        quiet_armed_next = 1'b1;
      end
      bbps_pkg::REQ_BRIGHT: begin
        quiet_count_next = 16'd0;
        quiet_armed_next = 1'b1;
        unique case (item.bright_cmd)
          bbps_pkg::CMD_DOWN: begin
            if (level == 8'd0) beep = 1'b1;
            else level_next = level - 8'd1;
          end
          bbps_pkg::CMD_UP: begin
            if (level >= cfg.top_index) beep = 1'b1;
            else level_next = level + 8'd1;
          end
          bbps_pkg::CMD_DEFAULT: level_next = cfg.default_index;
          default: ;
        endcase
        if (beep) begin
          beep_on_next    = 1'b1;
          beep_count_next = 16'd0;
        end
        change_count_next = 16'd0;
        change_armed_next = 1'b1;
      end
      bbps_pkg::REQ_UNUSED: ;
      default: ;
    endcase

    res.bright_level  = level_next;
    res.apply_level   = (item.req_type == bbps_pkg::REQ_BRIGHT);
    res.beep_active   = beep_on_next;
    res.silence_alarm = alarm;
    res.erase_page    = erase;
    res.write_flash   = save;
    res.write_offset  = woff;
    res.write_value   = save ? level : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= 8'd0;
      saved_level  <= bbps_pkg::SAVED_INIT_RST;
      page_offset  <= bbps_pkg::OFFSET_INIT_RST;
      quiet_count  <= 16'd0;
      quiet_armed  <= 1'b1;
      beep_count   <= 16'd0;
      beep_on      <= 1'b0;
      change_count <= 16'd0;
      change_armed <= 1'b0;
    end else begin
      if (fire) begin
        level        <= level_next;
        saved_level  <= saved_level_next;
        page_offset  <= page_offset_next;
        quiet_count  <= quiet_count_next;
        quiet_armed  <= quiet_armed_next;
        beep_count   <= beep_count_next;
        beep_on      <= beep_on_next;
        change_count <= change_count_next;
        change_armed <= change_armed_next;
      end
      // start-up loads must only arrive while idle; the block itself does not enforce it
      if (init_load.load_saved) saved_level <= init_load.saved_value;
      if (init_load.load_offset) page_offset <= init_load.offset_value;
    end
  end

endmodule

FILE: sv/brightness_step_beep_persist_supervisor.sv
// Top level of the brightness step/beep/persist supervisor.
// Depends on bbps_pkg, bbps_stream_if, bbps_cfg_regs and bbps_core.
//
//  channel  direction  payload                                   transfer when
//  item     in         req_type, bright_cmd                      valid && ready
//  status   out        bright_level .. write_value (8 fields)    valid && ready
//  cfg      in         cfg_index, cfg_data                       cfg_we
//
// Rate: one item per clock sustained while status is not stalled; each item is held in the
// input register and then sits in the status register, where status becomes valid.
// The step logic in bbps_core (16-bit saturating counts and compares) sets the cycle.
// Reset (rst, synchronous) empties both stages and restores registers and state.
// A stall on status holds the status register, then the input register; item
// ready drops only when both are full and status is stalled.
module brightness_step_beep_persist_supervisor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbps_pkg::CFG_DATA_W-1:0] cfg_data,
  bbps_stream_if.sink                     item,
  bbps_stream_if.source                   status
);

  bbps_pkg::cfg_t       cfg;
  bbps_pkg::init_load_t init_load;
  bbps_pkg::item_t      stage_item;
  bbps_pkg::status_t    stage_res;
  bbps_pkg::status_t    out_data;
  logic                 stage_valid;
  logic                 out_valid;
  logic                 advance;
  logic                 fire;

  bbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .init_load (init_load)
  );

  // Advance the pipe whenever the status register is empty or being taken.
  assign advance    = !out_valid || status.ready;
  assign fire       = stage_valid && advance;
  assign item.ready = !stage_valid || advance;

  // Hold the accepted item in the input register for the step logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      stage_item <= item.data;
    end
  end

  bbps_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .init_load (init_load),
    .fire      (fire),
    .item      (stage_item),
    .res       (stage_res)
  );

  // Capture the result as the core state updates; hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
    if (fire) begin
      out_data <= stage_res;
    end
  end

  assign status.valid = out_valid;
  assign status.data  = out_data;

endmodule

FILE: sv/bbps_checker.sv
// Port-level checks of the brightness supervisor, bound to the top level.
// Depends on bbps_pkg and brightness_step_beep_persist_supervisor_assert.svh.
`include "brightness_step_beep_persist_supervisor_assert.svh"

module bbps_checker (
  input logic              clk,
  input logic              rst,
  input logic              status_valid,
  input logic              status_ready,
  input bbps_pkg::status_t status_data
);

  logic held;
  logic no_write;
  logic write_clear;
  logic erase_seen;
  logic tick_flag;

  assign held        = status_valid && !status_ready;
  assign no_write    = status_valid && !status_data.write_flash;
  assign write_clear = (status_data.write_offset == 16'd0) && (status_data.write_value == 8'd0)
                       && !status_data.erase_page;
  assign erase_seen  = status_valid && status_data.erase_page;
  assign tick_flag   = status_valid && (status_data.silence_alarm || status_data.write_flash);

  `BBPS_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !status_valid, "status valid after reset")

  `BBPS_ASSERT_RUN(a_stall_holds, clk, rst, held |=> (status_valid && $stable(status_data)), "stall lost")

  `BBPS_ASSERT_RUN(a_idle_write_zero, clk, rst, no_write |-> write_clear, "write fields without write")

  `BBPS_ASSERT_RUN(a_erase_at_start, clk, rst, erase_seen |-> write_clear || 1'b0 || (status_data.write_offset == 16'd0), "erase off zero")

  `BBPS_ASSERT_RUN(a_tick_not_apply, clk, rst, tick_flag |-> !status_data.apply_level, "tick result flagged apply")

endmodule

bind brightness_step_beep_persist_supervisor bbps_checker u_bbps_checker (
  .clk          (clk),
  .rst          (rst),
  .status_valid (status.valid),
  .status_ready (status.ready),
  .status_data  (status.data)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the brightness step/beep/persist supervisor.
// Depends on bbps_pkg, bbps_stream_if and brightness_step_beep_persist_supervisor.
// Predicts every status transfer in a scoreboard class; plain tasks drive the ports.

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned REPORT_MAX     = 10;

  // Register values of one test phase, in register order.
  typedef struct {
    logic [15:0] silence_limit;
    logic [15:0] beep_length;
    logic [15:0] save_delay;
    logic [15:0] top_index;
    logic [15:0] default_index;
    logic [15:0] page_bytes;
    logic [15:0] saved_init;
    logic [15:0] offset_init;
  } reg_set_t;

  // Tracks the backlight state and holds the status transfers still due.
  class backlight_scoreboard;
    bbps_pkg::cfg_t    regs;
    logic [7:0]        level;
    logic [7:0]        saved_level;
    logic [15:0]       page_offset;
    logic [15:0]       quiet_count;
    logic [15:0]       beep_count;
    logic [15:0]       change_count;
    bit                quiet_armed;
    bit                beep_on;
    bit                change_armed;
    bbps_pkg::status_t status_due[$];
    int                errors;

    function new();
      regs.silence_limit_ms = bbps_pkg::SILENCE_LIMIT_RST;
      regs.beep_length_ms   = bbps_pkg::BEEP_LENGTH_RST;
      regs.save_delay_ms    = bbps_pkg::SAVE_DELAY_RST;
      regs.top_index        = bbps_pkg::TOP_INDEX_RST;
      regs.default_index    = bbps_pkg::DEFAULT_INDEX_RST;
      regs.page_bytes       = bbps_pkg::PAGE_BYTES_RST;
      level        = '0;
      saved_level  = bbps_pkg::SAVED_INIT_RST;
      page_offset  = bbps_pkg::OFFSET_INIT_RST;
      quiet_count  = '0;
      beep_count   = '0;
      change_count = '0;
      quiet_armed  = 1'b1;
      beep_on      = 1'b0;
      change_armed = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [bbps_pkg::CFG_IDX_W-1:0] idx,
                            logic [bbps_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        bbps_pkg::REG_SILENCE_LIMIT: regs.silence_limit_ms = data;
        bbps_pkg::REG_BEEP_LENGTH:   regs.beep_length_ms   = data;
        bbps_pkg::REG_SAVE_DELAY:    regs.save_delay_ms    = data;
        bbps_pkg::REG_TOP_INDEX:     regs.top_index        = data[7:0];
        bbps_pkg::REG_DEFAULT_INDEX: regs.default_index    = data[7:0];
        bbps_pkg::REG_PAGE_BYTES:    regs.page_bytes       = data;
        bbps_pkg::REG_SAVED_INIT:    saved_level           = data[7:0];
        bbps_pkg::REG_OFFSET_INIT:   page_offset           = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] sat_inc(logic [15:0] v);
      return (v == bbps_pkg::COUNT_MAX) ? v : v + 16'd1;
    endfunction

    // Advance the state by one accepted item and queue the status it causes.
    function void take_item(bbps_pkg::item_t it);
      bbps_pkg::status_t s;
      bit                beep;
      s    = '0;
      beep = 1'b0;
      case (it.req_type)
        bbps_pkg::REQ_TICK: begin
          quiet_count  = sat_inc(quiet_count);
          beep_count   = sat_inc(beep_count);
          change_count = sat_inc(change_count);
          if (quiet_armed && quiet_count > regs.silence_limit_ms) begin
            s.silence_alarm = 1'b1;
            quiet_armed     = 1'b0;
          end
          if (beep_on && beep_count >= regs.beep_length_ms)
            beep_on = 1'b0;
          if (change_armed && level != saved_level &&
              change_count > regs.save_delay_ms) begin
            change_armed = 1'b0;
            if (page_offset >= regs.page_bytes) begin
              s.erase_page = 1'b1;
              page_offset  = '0;
            end
            s.write_flash  = 1'b1;
            s.write_offset = page_offset;
            s.write_value  = level;
            page_offset    = page_offset + bbps_pkg::HALFWORD_BYTES;
            saved_level    = level;
          end
        end
        bbps_pkg::REQ_FRAME, bbps_pkg::REQ_BRIGHT: begin
          quiet_count = '0;
          quiet_armed = 1'b1;
          if (it.req_type == bbps_pkg::REQ_BRIGHT) begin
            case (it.bright_cmd)
              bbps_pkg::CMD_DOWN: begin
                if (level == 8'd0) beep = 1'b1;
                else level = level - 8'd1;
              end
              bbps_pkg::CMD_UP: begin
                if (level >= regs.top_index) beep = 1'b1;
                else level = level + 8'd1;
              end
              bbps_pkg::CMD_DEFAULT: level = regs.default_index;
              default: ;
            endcase
            if (beep) begin
              beep_on    = 1'b1;
              beep_count = '0;
            end
            s.apply_level = 1'b1;
            change_count  = '0;
            change_armed  = 1'b1;
          end
        end
        default: ;
      endcase
      s.bright_level = level;
      s.beep_active  = beep_on;
      status_due.push_back(s);
    endfunction

    function void check_status(bbps_pkg::status_t got);
      bbps_pkg::status_t exp;
      bit                bad;
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("tb: status transfer with nothing due: %h", got);
        return;
      end
      exp = status_due.pop_front();
      bad = (got.bright_level !== exp.bright_level) ||
            (got.apply_level !== exp.apply_level) ||
            (got.beep_active !== exp.beep_active) ||
            (got.silence_alarm !== exp.silence_alarm) ||
            (got.erase_page !== exp.erase_page) ||
            (got.write_flash !== exp.write_flash) ||
            (got.write_offset !== exp.write_offset) ||
            (got.write_value !== exp.write_value);
      if (bad) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("tb: status mismatch lvl/apl/bp/al/er/wr/off/val",
                   " exp %0d %b %b %b %b %b %0d %0d",
                   exp.bright_level, exp.apply_level, exp.beep_active, exp.silence_alarm,
                   exp.erase_page, exp.write_flash, exp.write_offset, exp.write_value,
                   " got %0d %b %b %b %b %b %0d %0d",
                   got.bright_level, got.apply_level, got.beep_active, got.silence_alarm,
                   got.erase_page, got.write_flash, got.write_offset, got.write_value);
      end
    endfunction

    function int due_count();
      return status_due.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [bbps_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bbps_pkg::CFG_DATA_W-1:0] cfg_data;

  bbps_stream_if #(.payload_t(bbps_pkg::item_t))   item_ch ();
  bbps_stream_if #(.payload_t(bbps_pkg::status_t)) status_ch ();

  brightness_step_beep_persist_supervisor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .status    (status_ch)
  );

  backlight_scoreboard sb = new();

  // Idling switches for the two sides; cleared for the back-to-back stretches.
  bit in_idle_on  = 1'b1;
  bit out_stall_on = 1'b1;
  int stall_left  = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  // Drive the result side: random stalls, mostly short, now and then long.
  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      status_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      status_ch.ready <= 1'b1;
      if (out_stall_on && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
    end
  end

  // Sample both channels on the edge: note each item transfer, check each
  // status transfer, and bail out if the block goes quiet for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready)
        sb.take_item(item_ch.data);
      if (status_ch.valid && status_ch.ready)
        sb.check_status(status_ch.data);
      if ((item_ch.valid && item_ch.ready) || (status_ch.valid && status_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (!in_idle_on) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bbps_pkg::item_t mk_item(logic [1:0] kind, logic [7:0] cmd);
    bbps_pkg::item_t it;
    it.req_type   = kind;
    it.bright_cmd = cmd;
    return it;
  endfunction

  // Mostly ticks and brightness commands, some plain frames, rare unused types.
  function automatic bbps_pkg::item_t rand_item();
    int r;
    int c;
    r = $urandom_range(0, 99);
    c = $urandom_range(0, 9);
    if (r < 45) return mk_item(bbps_pkg::REQ_TICK, 8'($urandom));
    if (r < 62) return mk_item(bbps_pkg::REQ_FRAME, 8'($urandom));
    if (r < 97) begin
      if (c < 3) return mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_DOWN);
      if (c < 6) return mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_UP);
      if (c < 7) return mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_DEFAULT);
      return mk_item(bbps_pkg::REQ_BRIGHT, 8'($urandom));
    end
    return mk_item(bbps_pkg::REQ_UNUSED, 8'($urandom));
  endfunction

  function automatic reg_set_t small_set();
    reg_set_t s;
    s.silence_limit = 16'($urandom_range(1, 40));
    s.beep_length   = 16'($urandom_range(1, 30));
    s.save_delay    = 16'($urandom_range(1, 40));
    s.top_index     = 16'($urandom_range(0, 255));
    s.default_index = 16'($urandom_range(0, 255));
    s.page_bytes    = 16'($urandom_range(2, 64));
    s.saved_init    = 16'($urandom_range(0, 255));
    s.offset_init   = 16'($urandom_range(0, 70));
    return s;
  endfunction

  // Present one item and hold it until transfer, then idle for a random gap.
  task automatic send_item(input bbps_pkg::item_t it);
    int gap;
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    gap = next_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every due status has come back.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_count() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [bbps_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Write all eight registers back to back; call only with the block idle.
  task automatic program_regs(input reg_set_t s);
    cfg_put(bbps_pkg::REG_SILENCE_LIMIT, s.silence_limit);
    cfg_put(bbps_pkg::REG_BEEP_LENGTH, s.beep_length);
    cfg_put(bbps_pkg::REG_SAVE_DELAY, s.save_delay);
    cfg_put(bbps_pkg::REG_TOP_INDEX, s.top_index);
    cfg_put(bbps_pkg::REG_DEFAULT_INDEX, s.default_index);
    cfg_put(bbps_pkg::REG_PAGE_BYTES, s.page_bytes);
    cfg_put(bbps_pkg::REG_SAVED_INIT, s.saved_init);
    cfg_put(bbps_pkg::REG_OFFSET_INIT, s.offset_init);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic with tick bursts that can run long enough to reach the save and
  // silence thresholds; optionally pause once until all status is back.
  task automatic run_random(input int n, input int burst_max, input bit pause_once);
    int  sent;
    int  len;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      if (pause_once && !paused && sent >= n / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, burst_max);
        repeat (len) send_item(mk_item(bbps_pkg::REQ_TICK, 8'($urandom)));
        sent += len;
      end else begin
        send_item(rand_item());
        sent++;
      end
    end
  endtask

  initial begin
    reg_set_t s;
    int       burst;

    // Hold every input at a known value from time zero.
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;

    // Hold reset, then release it once for the whole run.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, step down at zero, reapply, unused type.
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_DOWN));
    send_item(mk_item(bbps_pkg::REQ_TICK, 8'hFF));
    send_item(mk_item(bbps_pkg::REQ_FRAME, 8'h00));
    send_item(mk_item(bbps_pkg::REQ_UNUSED, 8'hFF));
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, 8'h00));
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_DEFAULT));
    drain();

    // Directed: tiny thresholds, small page, default above top index.
    s = '{16'd2, 16'd3, 16'd2, 16'd2, 16'd200, 16'd4, 16'd0, 16'd2};
    program_regs(s);
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_UP));
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_UP));
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_UP));      // at top: beep
    repeat (4) send_item(mk_item(bbps_pkg::REQ_TICK, 8'h00));        // alarm, beep off, save
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_DEFAULT)); // jump above top
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_UP));      // above top: beep
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_UP));      // restart count
    repeat (3) send_item(mk_item(bbps_pkg::REQ_TICK, 8'h55));        // page full: erase
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_DOWN));
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, 8'hFF));
    repeat (3) send_item(mk_item(bbps_pkg::REQ_TICK, 8'hAA));
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, 8'h80));                 // unchanged: no write
    repeat (3) send_item(mk_item(bbps_pkg::REQ_TICK, 8'h00));
    drain();

    // Random phases: fixed corner settings first, then random small ones.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: s = '{16'd5, 16'd4, 16'd8, 16'd15, 16'd7, 16'd8, 16'd0, 16'd0};
        1: s = '{16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd2, 16'd255, 16'd65535};
        2: s = '{16'd20, 16'd10, 16'd30, 16'd255, 16'd255, 16'd65534, 16'd3, 16'd65532};
        default: s = small_set();
      endcase
      program_regs(s);
      burst = 2 * ((s.save_delay > s.silence_limit) ? s.save_delay : s.silence_limit) + 4;
      // Run one phase back to back on both sides.
      in_idle_on   = (phase != 3);
      out_stall_on = (phase != 3);
      run_random(300, burst, phase == 0);
      drain();
    end

    // Widest limits with no idling anywhere: nothing times out or saves.
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    s = '{16'd65535, 16'd65534, 16'd65534, 16'd0, 16'd128, 16'd65534, 16'd0, 16'd0};
    program_regs(s);
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_DEFAULT));
    send_item(mk_item(bbps_pkg::REQ_BRIGHT, bbps_pkg::CMD_UP));
    repeat (60) send_item(mk_item(bbps_pkg::REQ_TICK, 8'($urandom)));
    drain();
    // Drop the silence limit below the running quiet count: next tick alarms.
    s.silence_limit = 16'd50;
    program_regs(s);
    repeat (3) send_item(mk_item(bbps_pkg::REQ_TICK, 8'h00));
    send_item(mk_item(bbps_pkg::REQ_FRAME, 8'h00));
    send_item(mk_item(bbps_pkg::REQ_TICK, 8'h00));
    drain();

    // Back to the reset settings for a final stretch of idling traffic.
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    s = '{bbps_pkg::SILENCE_LIMIT_RST, bbps_pkg::BEEP_LENGTH_RST, bbps_pkg::SAVE_DELAY_RST,
          16'(bbps_pkg::TOP_INDEX_RST), 16'(bbps_pkg::DEFAULT_INDEX_RST),
          bbps_pkg::PAGE_BYTES_RST, 16'(bbps_pkg::SAVED_INIT_RST), bbps_pkg::OFFSET_INIT_RST};
    program_regs(s);
    run_random(200, 60, 1'b0);

    // Wait out everything still due, then settle to catch stray transfers.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: brightness_step_beep_persist_supervisor.f
+incdir+sv
sv/bbps_pkg.sv
sv/bbps_stream_if.sv
sv/bbps_cfg_regs.sv
sv/bbps_core.sv
sv/brightness_step_beep_persist_supervisor.sv
sv/bbps_checker.sv
dv/tb.sv
